### design/integral_image_box_average_unit_defines.svh
// Assertion macros shared by the integral image box average unit.
// Depends on nothing; included by the files that assert.
`ifndef INTEGRAL_IMAGE_BOX_AVERAGE_UNIT_DEFINES_SVH
`define INTEGRAL_IMAGE_BOX_AVERAGE_UNIT_DEFINES_SVH
// Property that must hold at every clock edge outside reset.
`define IIBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define IIBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### design/iiba_pkg.sv
// Package for the integral image box average unit: types, constants, codes.
// Depends on nothing.
`default_nettype none
package iiba_pkg;
  localparam int unsigned DefMaxWidth  = 128;
  localparam int unsigned DefMaxHeight = 128;
  localparam int unsigned SumW = 32;
  localparam int unsigned PixW = 16;
  localparam int unsigned CfgW = 8;
  localparam int unsigned CoordW = 7;
  localparam int unsigned AvgW = 16;

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgBox    = 2'd2;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_RD, ST_LD_WAIT, ST_LD_WR,
    ST_Q_SETUP, ST_Q_RD, ST_Q_ACC, ST_Q_DIV, ST_Q_OUT
  } iiba_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the accepted item
    logic ld_rd;     // issue the read of the upper neighbour
    logic ld_wr;     // update left sum and write the entry
    logic q_setup;   // compute clamped window bounds
    logic q_rd;      // issue corner read, corner index below
    logic [1:0] corner;
    logic q_acc;     // accumulate the corner read last cycle
    logic acc_clr;
    logic div_start;
    logic out_load;
  } iiba_cmd_t;

  typedef struct packed {
    logic in_image;  // captured load lies inside the image
    logic div_done;
  } iiba_stat_t;
endpackage
`default_nettype wire

### design/integral_image_box_average_unit.sv
// Top level of the integral image box average unit.
// Depends on iiba_pkg, iiba_ctrl and iiba_datapath.
`default_nettype none
// Builds a 32-bit summed-area table from raster-order pixel loads and answers
// box-average queries. A load runs capture, upper-neighbour read and write
// through the single table memory port; a load outside the image is dropped
// after capture and decode. A query runs capture and decode, window setup,
// four corner reads from that port, each a read then an accumulate, then a
// 32-step restoring divider by the window area, then a hand-over of the result
// to the output register, delayed while an earlier result is still stalled
// there. One item at a time.
module integral_image_box_average_unit
  import iiba_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CfgW-1:0]   cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_action,
  input  wire logic [CoordW-1:0] in_row,
  input  wire logic [CoordW-1:0] in_col,
  input  wire logic [PixW-1:0]   in_pixel,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [AvgW-1:0]        out_average
);
  iiba_cmd_t cmd;
  iiba_stat_t stat;
  logic act;

  iiba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .act(act), .stat(stat), .cmd(cmd)
  );

  iiba_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_action(in_action), .in_row(in_row), .in_col(in_col),
    .in_pixel(in_pixel), .cmd(cmd), .stat(stat), .act(act), .avg(out_average)
  );
endmodule
`default_nettype wire

### design/iiba_divider.sv
// Restoring divider, one quotient bit per cycle, 32 by 32 bits.
// Depends on iiba_pkg.
`default_nettype none
module iiba_divider
  import iiba_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [SumW-1:0] dividend,
  input  wire logic [SumW-1:0] divisor,
  output logic                 done,
  output logic [SumW-1:0]      quotient
);
  localparam int unsigned CntW = $clog2(SumW + 1);
  logic [SumW-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [SumW:0]   trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r, quo_r[SumW-1]} - {1'b0, dvs_r};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CntW'(SumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[SumW]) begin
        rem_nxt = trial[SumW-1:0];
        quo_nxt = {quo_r[SumW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[SumW-2:0], quo_r[SumW-1]};
        quo_nxt = {quo_r[SumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done = busy_r && (cnt_r == CntW'(1));
  assign quotient = quo_nxt;
endmodule
`default_nettype wire

### design/iiba_datapath.sv
// Datapath: configuration, summed-area table memory, window arithmetic, divider.
// Depends on iiba_pkg and iiba_divider.
`default_nettype none
module iiba_datapath
  import iiba_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CfgW-1:0]   cfg_data,
  input  wire logic              in_action,
  input  wire logic [CoordW-1:0] in_row,
  input  wire logic [CoordW-1:0] in_col,
  input  wire logic [PixW-1:0]   in_pixel,
  input  wire iiba_cmd_t         cmd,
  output iiba_stat_t             stat,
  output logic                   act,
  output logic [AvgW-1:0]        avg
);
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  // Signed coordinate width, enough for -1 .. max + 255.
  localparam int unsigned CW = ((WW > HW) ? WW : HW) + 10;

  logic [CfgW-1:0] width_r, height_r, box_r;
  logic [WW-1:0] ew;
  logic [HW-1:0] eh;
  logic act_r;
  logic [CoordW-1:0] row_r, col_r;
  logic [PixW-1:0] pix_r;
  logic [SumW-1:0] mem [Depth];
  logic [SumW-1:0] rd_r, left_r, acc_r, area_r;
  logic [AddrW-1:0] addr;
  logic signed [CW-1:0] north_r, south_r, west_r, east_r;
  logic signed [CW-1:0] cr, cc, rc, ccl, rad, nv, sv, wv, evv;
  logic zero_r;
  logic [SumW-1:0] quo;
  logic [AvgW-1:0] avg_r;
  logic [CfgW-1:0] side;
  logic in_image;
  logic div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CfgW'(8);
      height_r <= CfgW'(8);
      box_r <= CfgW'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CfgWidth: width_r <= cfg_data;
        CfgHeight: height_r <= cfg_data;
        CfgBox: box_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) ew = WW'(1);
    else if (WW'(width_r) > WW'(MAX_WIDTH) || int'(width_r) > MAX_WIDTH) ew = WW'(MAX_WIDTH);
    else ew = WW'(width_r);
    if (height_r == '0) eh = HW'(1);
    else if (int'(height_r) > MAX_HEIGHT) eh = HW'(MAX_HEIGHT);
    else eh = HW'(height_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      row_r <= in_row;
      col_r <= in_col;
      pix_r <= in_pixel;
    end
  end

  assign in_image = (int'(row_r) < int'(eh)) && (int'(col_r) < int'(ew));
  assign stat = '{in_image: in_image, div_done: div_done};
  assign act = act_r;

  // Query window, clamped.
  always_comb begin
    side = (box_r == '0) ? CfgW'(1) : box_r;
    if (!side[0]) side = side - 1'b1;
    rad = CW'(side[CfgW-1:1]);
    rc = (int'(row_r) >= int'(eh)) ? CW'(eh) - CW'(1) : CW'(row_r);
    ccl = (int'(col_r) >= int'(ew)) ? CW'(ew) - CW'(1) : CW'(col_r);
    nv = rc - rad - CW'(1);
    if (nv < 0) nv = -CW'(1);
    sv = rc + rad;
    if (sv > CW'(eh) - CW'(1)) sv = CW'(eh) - CW'(1);
    wv = ccl - rad - CW'(1);
    if (wv < 0) wv = -CW'(1);
    evv = ccl + rad;
    if (evv > CW'(ew) - CW'(1)) evv = CW'(ew) - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.q_setup) begin
      north_r <= nv;
      south_r <= sv;
      west_r <= wv;
      east_r <= evv;
    end
  end

  // Corner selection; bit 1 picks north, bit 0 picks west.
  always_comb begin
    cr = cmd.corner[1] ? north_r : south_r;
    cc = cmd.corner[0] ? west_r : east_r;
    if (cmd.q_rd) addr = AddrW'(cr * CW'(ew) + cc);
    else if (cmd.ld_rd) addr = AddrW'((CW'(row_r) - 1) * CW'(ew) + CW'(col_r));
    else addr = AddrW'(CW'(row_r) * CW'(ew) + CW'(col_r));
  end

  logic [SumW-1:0] left_nxt;
  assign left_nxt = (col_r == '0) ? SumW'(signed'(pix_r))
                                  : left_r + SumW'(signed'(pix_r));

  always_ff @(posedge clk) begin
    if (cmd.ld_wr) mem[addr] <= left_nxt + ((row_r == '0) ? '0 : rd_r);
    if (cmd.ld_rd || cmd.q_rd) rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) left_r <= '0;
    else if (cmd.ld_wr) left_r <= left_nxt;
  end

  // Accumulator: corner code captured with the read.
  logic [1:0] corn_r;
  always_ff @(posedge clk) begin
    if (cmd.q_rd) begin
      corn_r <= cmd.corner;
      zero_r <= (cr < 0) || (cc < 0);
    end
    if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.q_acc && !zero_r) begin
      if (corn_r == 2'd0 || corn_r == 2'd3) acc_r <= acc_r + rd_r;
      else acc_r <= acc_r - rd_r;
    end
    if (cmd.q_setup) area_r <= SumW'(sv - nv) * SumW'(evv - wv);
  end

  iiba_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(acc_r),
    .divisor(area_r), .done(div_done), .quotient(quo)
  );

  // The quotient holds once the divider has finished, so the output register
  // is loaded only when the previous result has left.
  always_ff @(posedge clk) begin
    if (cmd.out_load) avg_r <= quo[AvgW-1:0];
  end
  assign avg = avg_r;
endmodule
`default_nettype wire

### design/iiba_ctrl.sv
// Controller state machine sequencing loads and queries, and the output register.
// Depends on iiba_pkg and the assertion macro header.
`default_nettype none
`include "integral_image_box_average_unit_defines.svh"
module iiba_ctrl
  import iiba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire logic act,
  input  wire iiba_stat_t stat,
  output iiba_cmd_t cmd
);
  iiba_state_t state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    ov_nxt = ov_r;
    cmd = '0;
    in_stall = 1'b1;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = ST_LD_RD;
        end
      end
      ST_LD_RD: begin
        if (act == ActQuery) state_nxt = ST_Q_SETUP;
        else if (!stat.in_image) state_nxt = ST_IDLE;
        else begin
          cmd.ld_rd = 1'b1;
          state_nxt = ST_LD_WR;
        end
      end
      ST_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_Q_SETUP: begin
        cmd.q_setup = 1'b1;
        cmd.acc_clr = 1'b1;
        k_nxt = '0;
        state_nxt = ST_Q_RD;
      end
      ST_Q_RD: begin
        cmd.q_rd = 1'b1;
        cmd.corner = k_r;
        state_nxt = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        cmd.q_acc = 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r == 2'd3) begin
          state_nxt = ST_Q_DIV;
        end else state_nxt = ST_Q_RD;
      end
      ST_Q_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_LD_WAIT;
      end
      ST_LD_WAIT: begin
        if (stat.div_done) state_nxt = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;

  `IIBA_ASSERT(a_accept_idle, !(in_valid && !in_stall) || state_r == ST_IDLE,
    "item accepted outside idle")
  `IIBA_ASSERT_NEXT(a_out_hold, ov_r && out_stall, ov_r, "result dropped while stalled")
  `IIBA_ASSERT_NEXT(a_div_out, state_r == ST_LD_WAIT && stat.div_done,
    state_r == ST_Q_OUT, "divider finish missed")
endmodule
`default_nettype wire
